>>> src/life_pkg.sv
package life_pkg;

  // Largest board side that the line store holds
  localparam int MAX_SIZE = 1024;

  // Width of the configuration write data
  localparam int CFG_W = 11;
  // Side length at reset
  localparam int BOARD_RESET = 20;

  // Column index and line store address
  localparam int COL_W = $clog2(MAX_SIZE);
  // Row index and side length; a row runs up to side + 1 during the flush
  localparam int POS_W = $clog2(MAX_SIZE + 2);
  // Coordinates on the result channel
  localparam int OUT_W = 10;

  // Line store entry: bit 0 row above, bit 1 two rows above
  localparam int LS_W = 2;

  // Result queue
  localparam int OQ_DEPTH = 3;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // Input kind codes
  localparam logic KIND_CELL  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // One accepted item on its way into the cell evaluation stage
  typedef struct packed {
    logic             vld;
    logic             alive;
    logic [POS_W-1:0] row;
    logic [COL_W-1:0] col;
  } life_item_t;

  // One result on its way to the output queue
  typedef struct packed {
    logic             next_alive;
    logic [OUT_W-1:0] row;
    logic [OUT_W-1:0] col;
    logic             last;
  } life_res_t;

endpackage

>>> src/life_ram.sv
module life_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

>>> src/life_seq.sv
module life_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_fire,
  input  logic                          in_kind,
  input  logic                          in_alive,
  input  logic                          cfg_fire,
  input  logic [life_pkg::CFG_W-1:0]    cfg_data,
  output life_pkg::life_item_t          item,
  output logic [life_pkg::POS_W-1:0]    side,
  output logic [life_pkg::COL_W-1:0]    rd_addr
);
  import life_pkg::*;

  logic [POS_W-1:0] side_r, side_nxt;
  logic [POS_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0] in_col_r, in_col_nxt;
  life_item_t       item_r, item_nxt;
  logic [POS_W-1:0] col_inc;
  logic             end_of_pass;

  // Clamp the side length into 1 .. MAX_SIZE
  always_comb begin
    side_nxt = side_r;
    if (cfg_fire) begin
      if (cfg_data == '0) begin
        side_nxt = POS_W'(1);
      end else if (32'(cfg_data) > 32'(MAX_SIZE)) begin
        side_nxt = POS_W'(MAX_SIZE);
      end else begin
        side_nxt = POS_W'(cfg_data);
      end
    end
  end

  assign col_inc     = POS_W'(in_col_r) + POS_W'(1);
  assign end_of_pass = (in_col_r == '0) && (in_row_r == side_r + POS_W'(1));

  // Advance the raster position; wrap to the origin after the last result or on a configuration write
  always_comb begin
    in_row_nxt = in_row_r;
    in_col_nxt = in_col_r;
    if (cfg_fire) begin
      in_row_nxt = '0;
      in_col_nxt = '0;
    end else if (in_fire) begin
      if (end_of_pass) begin
        in_row_nxt = '0;
        in_col_nxt = '0;
      end else if (col_inc >= side_r) begin
        in_row_nxt = in_row_r + POS_W'(1);
        in_col_nxt = '0;
      end else begin
        in_col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_comb begin
    item_nxt       = item_r;
    item_nxt.vld   = in_fire;
    if (in_fire) begin
      item_nxt.alive = in_alive & (in_kind == KIND_CELL);
      item_nxt.row   = in_row_r;
      item_nxt.col   = in_col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r     <= POS_W'(BOARD_RESET);
      in_row_r   <= '0;
      in_col_r   <= '0;
      item_r.vld <= 1'b0;
    end else begin
      side_r     <= side_nxt;
      in_row_r   <= in_row_nxt;
      in_col_r   <= in_col_nxt;
      item_r.vld <= item_nxt.vld;
    end
    item_r.alive <= item_nxt.alive;
    item_r.row   <= item_nxt.row;
    item_r.col   <= item_nxt.col;
  end

  assign item    = item_r;
  assign side    = side_r;
  assign rd_addr = in_col_r;

endmodule

>>> src/life_eval.sv
module life_eval (
  input  logic                          clk,
  input  logic                          rst_n,
  input  life_pkg::life_item_t          item,
  input  logic [life_pkg::POS_W-1:0]    side,
  input  logic                          clr,
  input  logic                          rd_en,
  input  logic [life_pkg::COL_W-1:0]    rd_addr,
  input  logic [life_pkg::LS_W-1:0]     rd_data,
  output logic                          wr_en,
  output logic [life_pkg::COL_W-1:0]    wr_addr,
  output logic [life_pkg::LS_W-1:0]     wr_data,
  output logic                          res_vld,
  output life_pkg::life_res_t           res
);
  import life_pkg::*;

  function automatic logic [3:0] popcount9(input logic [8:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 9; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

  function automatic logic life_rule(input logic centre, input logic [3:0] n);
    return (n == 4'd3) || (centre && (n == 4'd2));
  endfunction

  logic [8:0]       window_r, window_nxt;
  logic             fwd_hit_r;
  logic [LS_W-1:0]  fwd_data_r;
  logic [LS_W-1:0]  stored;
  logic [2:0]       column;
  logic [8:0]       win_sh;
  logic [8:0]       mask_a, mask_b;
  logic             emit_a, emit_b, last_b;
  logic [POS_W-1:0] row_m1, row_m2, side_m1;
  logic [POS_W:0]   side_p1;

  // Take the forwarded write data when the read hit the entry written alongside it
  assign stored  = fwd_hit_r ? fwd_data_r : rd_data;
  assign column  = {stored[1], stored[0], item.alive};
  assign win_sh  = {window_r[5:0], column};

  assign wr_en   = item.vld;
  assign wr_addr = item.col;
  assign wr_data = {stored[0], item.alive};

  assign row_m1  = item.row - POS_W'(1);
  assign row_m2  = item.row - POS_W'(2);
  assign side_m1 = side - POS_W'(1);
  assign side_p1 = {1'b0, side} + (POS_W + 1)'(1);

  assign emit_a  = (item.col != '0) && (item.row != '0);
  assign emit_b  = (item.col == '0) && (item.row >= POS_W'(2));
  assign last_b  = ({1'b0, item.row} == side_p1);

  // Neighbor masks: drop columns and rows that lie outside the board
  always_comb begin
    mask_a = 9'h1EF;
    if (item.col < COL_W'(2)) begin
      mask_a = mask_a & ~9'h1C0;
    end
    if (item.row < POS_W'(2)) begin
      mask_a = mask_a & ~9'h124;
    end
    if (item.row >= side) begin
      mask_a = mask_a & ~9'h049;
    end
    mask_b = 9'h03D;
    if (side < POS_W'(2)) begin
      mask_b = mask_b & ~9'h038;
    end
    if (item.row < POS_W'(3)) begin
      mask_b = mask_b & ~9'h024;
    end
    if (row_m1 >= side) begin
      mask_b = mask_b & ~9'h009;
    end
  end

  always_comb begin
    res_vld = item.vld && (emit_a || emit_b);
    if (emit_a) begin
      res.next_alive = life_rule(win_sh[4], popcount9(win_sh & mask_a));
      res.row        = row_m1[OUT_W-1:0];
      res.col        = OUT_W'(item.col - COL_W'(1));
      res.last       = 1'b0;
    end else begin
      res.next_alive = life_rule(window_r[1], popcount9(window_r & mask_b));
      res.row        = row_m2[OUT_W-1:0];
      res.col        = side_m1[OUT_W-1:0];
      res.last       = last_b;
    end
  end

  always_comb begin
    window_nxt = window_r;
    if (clr) begin
      window_nxt = '0;
    end else if (item.vld) begin
      window_nxt = (emit_b && last_b) ? 9'h000 : win_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= '0;
      fwd_hit_r <= 1'b0;
    end else begin
      window_r  <= window_nxt;
      fwd_hit_r <= rd_en && item.vld && (rd_addr == item.col);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= wr_data;
  end

endmodule

>>> src/life_outq.sv
module life_outq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  life_pkg::life_res_t           push_data,
  input  logic                          pop,
  output logic                          not_empty,
  output life_pkg::life_res_t           head,
  output logic [life_pkg::OQ_CNT_W-1:0] count
);
  import life_pkg::*;

  life_res_t           ent_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OQ_CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : wr_ptr_r + OQ_PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : rd_ptr_r + OQ_PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + OQ_CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - OQ_CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  assign not_empty = (cnt_r != '0);
  assign head      = ent_r[rd_ptr_r];
  assign count     = cnt_r;

endmodule

>>> src/life_automaton_generation.sv
// One generation of Life (birth on three neighbors, survival on two or three)
// over a square board of board_size x board_size cells, streamed in raster
// order at one cell per clock while in_ready is high. Send the board row by row
// on in_kind = 0, then exactly board_size + 1 flush transactions (in_kind = 1).
// Each result names the cell it belongs to; it comes out once the cell's
// lower-right neighbor or a flush has arrived, so results trail the input by
// board_size + 1 transactions, and the final cell of the board carries out_last.
// Cells beyond the edge count as dead. The block sustains one transaction per
// clock on both channels while out_ready stays high: the two-row line store
// is a single 1024 x 2 memory that is read and written once per cell, and the
// output queue decouples the two sides. A result passes the sequencer's item
// register and then the output queue before it shows on out_valid. Writing
// cfg_board_size restarts the pass (0 acts as 1, values above 1024 as 1024);
// write it only while no transaction is in flight. After reset the side is 20.
module life_automaton_generation (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic                          in_alive,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_next_alive,
  output logic [life_pkg::OUT_W-1:0]    out_cell_row,
  output logic [life_pkg::OUT_W-1:0]    out_cell_col,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [life_pkg::CFG_W-1:0]    cfg_board_size
);
  import life_pkg::*;

  logic                in_fire;
  logic                cfg_fire;
  logic                out_fire;
  life_item_t          item;
  logic [POS_W-1:0]    side;
  logic [COL_W-1:0]    rd_addr;
  logic [LS_W-1:0]     rd_data;
  logic                wr_en;
  logic [COL_W-1:0]    wr_addr;
  logic [LS_W-1:0]     wr_data;
  logic                res_vld;
  life_res_t           res;
  life_res_t           head;
  logic [OQ_CNT_W-1:0] q_count;

  // Configuration is always taken; the host must write it only between passes, which the block does not enforce
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  // Accept while the queue has room for everything already in flight,
  // counting the cell now in the evaluation stage
  assign in_ready = ((OQ_CNT_W + 1)'(q_count) + (OQ_CNT_W + 1)'(item.vld))
                    < (OQ_CNT_W + 1)'(OQ_DEPTH);

  // Raster position, side length and the launch of the line store read
  life_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_kind  (in_kind),
    .in_alive (in_alive),
    .cfg_fire (cfg_fire),
    .cfg_data (cfg_board_size),
    .item     (item),
    .side     (side),
    .rd_addr  (rd_addr)
  );

  // Line store: the two rows above, one entry per column
  life_ram #(
    .WIDTH (LS_W),
    .DEPTH (MAX_SIZE)
  ) u_line_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (in_fire),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Window shift, neighbor count and line store write-back
  life_eval u_eval (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item),
    .side    (side),
    .clr     (cfg_fire),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .res_vld (res_vld),
    .res     (res)
  );

  // Hold results until the consumer takes them
  life_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res),
    .pop       (out_fire),
    .not_empty (out_valid),
    .head      (head),
    .count     (q_count)
  );

  assign out_next_alive = head.next_alive;
  assign out_cell_row   = head.row;
  assign out_cell_col   = head.col;
  assign out_last       = head.last;

endmodule

>>> src/life_chk.sv
module life_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_next_alive,
  input logic [life_pkg::OUT_W-1:0]    out_cell_row,
  input logic [life_pkg::OUT_W-1:0]    out_cell_col,
  input logic                          out_last
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_alive) &&
      $stable(out_cell_row) && $stable(out_cell_col) && $stable(out_last))
    else $error("stalled result changed");

  // Reset empties the result queue
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // Reset leaves the block ready for a new cell
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

  // A result only appears after an input transaction has passed the item register into the result queue
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a releasing transaction");

endmodule

bind life_automaton_generation life_chk u_life_chk (.*);

>>> tb/life_automaton_generation_tb.sv
`timescale 1ns / 100ps

module life_automaton_generation_tb;
  import life_pkg::*;

  // Settle time before a board_size write: covers the result path through the item
  // register and the output queue plus items still in flight that release nothing.
  localparam int SETTLE_CYCLES  = 8;
  // Cycles with no transaction on any channel before the run is abandoned
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 450;

  // 3x3 window layout: column j sits in bits [3j+2:3j], j = 0 newest.
  // Within a column: bit 2 = two rows up, bit 1 = one row up, bit 0 = current row.
  localparam logic [8:0] WIN_RING   = 9'h1EF;  // eight neighbors of bit 4
  localparam logic [8:0] WIN_LEFT   = 9'h1C0;  // oldest column
  localparam logic [8:0] WIN_TOP    = 9'h124;  // top row of every column
  localparam logic [8:0] WIN_BOTTOM = 9'h049;  // bottom row of every column
  localparam logic [8:0] EDGE_RING  = 9'h03D;  // neighbors of bit 1, two newest columns
  localparam logic [8:0] EDGE_LEFT  = 9'h038;  // middle column seen from bit 1

  typedef enum logic [1:0] {
    ROW_SIZE,    // write board_size
    ROW_ITEM,    // send item, predictor decides the result
    ROW_PINNED   // send item, result typed into the table
  } row_op_t;

  typedef struct packed {
    row_op_t          op;
    logic [4:0]       reps;
    logic [CFG_W-1:0] size;
    logic             kind;
    logic             alive;
    life_res_t        want;
  } script_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_kind;
  logic                in_alive;
  logic                out_valid;
  logic                out_ready;
  logic                out_next_alive;
  logic [OUT_W-1:0]    out_cell_row;
  logic [OUT_W-1:0]    out_cell_col;
  logic                out_last;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_board_size;

  // Generation predictor state
  logic [CFG_W-1:0]    board_q;
  logic [LS_W-1:0]     line_mem [MAX_SIZE];
  logic [8:0]          window_q;
  logic [POS_W-1:0]    cur_row;
  logic [POS_W-1:0]    cur_col;

  life_res_t           pending_cells [$];
  script_row_t         script [6];
  int                  mismatches;
  int                  items_sent;
  int                  stall_cycles = 0;
  bit                  in_bursts_on;
  bit                  no_idle;

  life_automaton_generation u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_alive       (in_alive),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_next_alive (out_next_alive),
    .out_cell_row   (out_cell_row),
    .out_cell_col   (out_cell_col),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_board_size (cfg_board_size)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Side actually used: zero acts as one, oversize clamps to the line store.
  function automatic logic [POS_W-1:0] board_side();
    if (board_q == '0) return POS_W'(1);
    if (board_q > MAX_SIZE) return POS_W'(MAX_SIZE);
    return board_q[POS_W-1:0];
  endfunction

  // Return to the top-left corner; the line store keeps its contents.
  function automatic void clear_pass();
    window_q = '0;
    cur_row  = '0;
    cur_col  = '0;
  endfunction

  // Birth on three, survival on two or three
  function automatic logic life_rule(input logic centre, input int count);
    return (count == 3) || (centre && count == 2);
  endfunction

  // Advance the stream by one item; return 1 when it releases a cell.
  function automatic bit step_generation(input logic kind, input logic alive_in,
                                         output life_res_t res);
    logic [POS_W-1:0] n;
    logic [POS_W-1:0] r;
    logic [POS_W-1:0] c;
    logic             alive;
    logic [LS_W-1:0]  held;
    logic [8:0]       prior;
    logic [8:0]       mask;
    bit               fired;
    n     = board_side();
    r     = cur_row;
    c     = cur_col;
    alive = alive_in & (kind == KIND_CELL);
    prior = window_q;
    res   = '0;
    fired = 1'b0;

    // Shift the column down the line store and into the window
    held = line_mem[c[COL_W-1:0]];
    line_mem[c[COL_W-1:0]] = {held[0], alive};
    window_q = {prior[5:0], held[1], held[0], alive};

    if (c >= 1 && r >= 1) begin
      // Centre (r-1, c-1) is complete: its lower-right neighbor just arrived
      mask = WIN_RING;
      if (c < 2) mask &= ~WIN_LEFT;
      if (r < 2) mask &= ~WIN_TOP;
      if (r >= n) mask &= ~WIN_BOTTOM;
      res.next_alive = life_rule(window_q[4], $countones(window_q & mask));
      res.row = OUT_W'(r - 1);
      res.col = OUT_W'(c - 1);
      fired = 1'b1;
    end else if (c == 0 && r >= 2) begin
      // Wrap: release the last column of row r-2 from the pre-shift window
      mask = EDGE_RING;
      if (n < 2) mask &= ~EDGE_LEFT;
      if (r < 3) mask &= ~WIN_TOP;
      if (r - 1 >= n) mask &= ~WIN_BOTTOM;
      res.next_alive = life_rule(prior[1], $countones(prior & mask));
      res.row  = OUT_W'(r - 2);
      res.col  = OUT_W'(n - 1);
      res.last = (r == n + 1);
      fired = 1'b1;
    end

    c = c + POS_W'(1);
    if (c >= n) begin
      c = '0;
      r = r + POS_W'(1);
    end
    cur_row = r;
    cur_col = c;
    if (res.last) clear_pass();
    return fired;
  endfunction

  // Offer one input transaction, hold it until taken, then predict.
  task automatic drive_item(input logic kind, input logic alive, input bit pinned,
                            input life_res_t want);
    life_res_t res;
    bit        fired;
    in_kind  <= kind;
    in_alive <= alive;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    fired = step_generation(kind, alive, res);
    // A typed row overrides the prediction for that cell
    if (pinned) pending_cells.push_back(want);
    else if (fired) pending_cells.push_back(res);
    items_sent++;
    if (in_bursts_on && !no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  // Write board_size once the block has drained; the pass restarts.
  task automatic set_board(input logic [CFG_W-1:0] size);
    in_valid <= 1'b0;
    while (pending_cells.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_board_size <= size;
    cfg_valid      <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    board_q = size;
    clear_pass();
  endtask

  task automatic note_failure(input string what, input life_res_t due, input life_res_t seen);
    if (mismatches < 10) begin
      $display("%0t %s: expected next=%0b row=%0d col=%0d last=%0b,",
               $realtime, what, due.next_alive, due.row, due.col, due.last);
      $display("  got next=%0b row=%0d col=%0d last=%0b",
               seen.next_alive, seen.row, seen.col, seen.last);
    end
    mismatches++;
  endtask

  // Check every result transaction against the oldest pending cell.
  always @(posedge clk) begin
    life_res_t seen;
    life_res_t due;
    if (rst_n && out_valid && out_ready) begin
      seen = {out_next_alive, out_cell_row, out_cell_col, out_last};
      if (pending_cells.size() == 0) begin
        note_failure("result with nothing pending", '0, seen);
      end else begin
        due = pending_cells.pop_front();
        if (seen !== due) note_failure("cell mismatch", due, seen);
      end
    end
  end

  // Abort when no channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side back-pressure: random bursts of stalled cycles, switched on
  // and off in spans so that some stretches run with no stalls at all.
  initial begin : sink_stalls
    int hold_left;
    int span_left;
    bit stalls_on;
    out_ready = 1'b0;
    hold_left = 0;
    span_left = 0;
    stalls_on = 1'b0;
    forever begin
      @(negedge clk);
      if (span_left == 0) begin
        span_left = $urandom_range(16, 96);
        stalls_on = $urandom_range(0, 2) != 0;
      end
      span_left--;
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= 1'b1;
        if (stalls_on && !no_idle && $urandom_range(0, 3) == 0)
          hold_left = $urandom_range(1, 4);
      end
    end
  end

  initial begin
    logic [CFG_W-1:0] size;
    int               n;
    int               density;
    int               random_start;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = KIND_CELL;
    in_alive       = 1'b0;
    cfg_valid      = 1'b0;
    cfg_board_size = '0;
    mismatches     = 0;
    items_sent     = 0;
    in_bursts_on   = 1'b1;
    no_idle        = 1'b0;
    board_q        = CFG_W'(BOARD_RESET);
    foreach (line_mem[i]) line_mem[i] = '0;
    clear_pass();

    script = '{
      // Reset side is 20: flushes count as dead cells, so the 22nd position
      // releases a dead top-left corner
      '{ROW_ITEM,   5'd21, '0, KIND_FLUSH, 1'b1, '0},
      '{ROW_PINNED, 5'd1,  '0, KIND_FLUSH, 1'b0, '{1'b0, 10'd0, 10'd0, 1'b0}},
      // Zero acts as a 1x1 board; the write abandons the pass above
      '{ROW_SIZE,   5'd1,  '0, KIND_CELL,  1'b0, '0},
      '{ROW_ITEM,   5'd1,  '0, KIND_CELL,  1'b1, '0},
      // Live cell sent during the flush phase lands outside the board
      '{ROW_ITEM,   5'd1,  '0, KIND_CELL,  1'b1, '0},
      // Lone cell has no neighbors and dies; it is the last of the board
      '{ROW_PINNED, 5'd1,  '0, KIND_FLUSH, 1'b1, '{1'b0, 10'd0, 10'd0, 1'b1}}
    };

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (script[i]) begin
      if (script[i].op == ROW_SIZE) begin
        set_board(script[i].size);
      end else begin
        repeat (script[i].reps)
          drive_item(script[i].kind, script[i].alive, script[i].op == ROW_PINNED,
                     script[i].want);
      end
    end

    // Random boards: mostly well-formed passes with random density, some
    // broken streams with flushes and cells mixed at random
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       size = '0;
        1:       size = CFG_W'(1);
        2:       size = CFG_W'(2);
        8, 9:    size = CFG_W'($urandom_range(9, 12));
        default: size = CFG_W'($urandom_range(3, 8));
      endcase
      set_board(size);
      n = board_side();
      repeat ($urandom_range(1, 3)) begin
        in_bursts_on = $urandom_range(0, 2) != 0;
        density = $urandom_range(0, 100);
        if ($urandom_range(0, 4) != 0) begin
          repeat (n * n) drive_item(KIND_CELL, $urandom_range(0, 99) < density, 1'b0, '0);
          repeat (n + 1) drive_item(KIND_FLUSH, 1'($urandom_range(0, 1)), 1'b0, '0);
        end else begin
          repeat ($urandom_range(1, n * n + n + 4))
            drive_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
        end
      end
    end

    // Last pass with idling off: one full board and its flush back to back
    no_idle = 1'b1;
    set_board(CFG_W'($urandom_range(3, 8)));
    n = board_side();
    repeat (n * n) drive_item(KIND_CELL, 1'($urandom_range(0, 1)), 1'b0, '0);
    repeat (n + 1) drive_item(KIND_FLUSH, 1'b0, 1'b0, '0);
    in_valid <= 1'b0;

    // Drain, then let stray results show up before the verdict
    while (pending_cells.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
